/* hw/rtl/sbi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbi_pkg: shared types and constants of the bounded index generator
// Holds the generator constants, the controller state type and the status
// struct that the serial arithmetic units report through.
// ----------------------------------------------------------------------------
package sbi_pkg;

    // Word width of the generator, the bound and the index.
    localparam int DW = 64;

    // Generator increment and mixing constants.
    localparam logic [DW-1:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [DW-1:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [DW-1:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;
    localparam int SHIFT_A = 30;
    localparam int SHIFT_B = 27;
    localparam int SHIFT_C = 31;

    // Bit counter of the serial units, one step per bit of the word.
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THR_RUN,
        ST_DRAW,
        ST_MUL_A,
        ST_MUL_B,
        ST_CHECK,
        ST_RED_RUN,
        ST_HOLD
    } t_fsm;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage
`default_nettype wire

/* hw/rtl/splitmix64_bounded_index.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// splitmix64_bounded_index: unbiased bounded index from a SplitMix64 stream
// Takes an exclusive upper bound per item and returns a uniform index below
// it, drawing generator outputs and rejecting those under the bias threshold.
//
//   Channel   Direction  Payload (from bit 0 up)
//   s_axis    in         tdata[63:0] = bound
//   m_axis    out        tdata[63:0] = index
//   cfg       in         wdata[63:0] = seed, loads the generator state
//
// Each item computes the bias threshold for a nonzero bound, draws, checks
// the draw against the threshold and reduces a kept draw modulo the bound;
// a rejected draw is drawn again. A zero bound skips both remainders and
// returns the draw itself. Both bit-serial units take one bit per cycle.
// Reset clears the generator state to zero; a seed write reloads it.
// A stalled output holds its index while the next item runs in the controller.
// ----------------------------------------------------------------------------
module splitmix64_bounded_index (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Seed register write.
    input  wire logic                    i_cfg_we,
    input  wire logic [sbi_pkg::DW-1:0]  i_cfg_wdata,
    // Request stream.
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [sbi_pkg::DW-1:0]  s_axis_tdata,   // [63:0] bound
    // Result stream.
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [sbi_pkg::DW-1:0]       m_axis_tdata    // [63:0] index
);
    import sbi_pkg::*;

    t_fsm          r_fsm;
    t_fsm          n_fsm;
    logic [DW-1:0] r_gen;
    logic [DW-1:0] r_bound;
    logic [DW-1:0] r_thr;
    logic [DW-1:0] r_z;
    logic          r_out_valid;
    logic [DW-1:0] r_out_data;

    logic          w_in_acc;
    logic          w_keep;
    logic          w_load;
    logic [DW-1:0] w_gen_next;
    logic [DW-1:0] w_z0;
    logic [DW-1:0] w_z1;
    logic [DW-1:0] w_draw;

    logic          w_mul_start;
    logic [DW-1:0] w_mul_a;
    logic [DW-1:0] w_mul_b;
    t_unit_stat    w_mul_stat;
    logic [DW-1:0] w_mul_res;

    logic          w_mod_start;
    logic [DW-1:0] w_mod_dvd;
    logic [DW-1:0] w_mod_div;
    t_unit_stat    w_mod_stat;
    logic [DW-1:0] w_mod_res;

    // Mixing steps between the multiplier passes.
    always_comb begin
        w_gen_next = r_gen + GOLDEN_GAMMA;
        w_z0       = w_gen_next ^ (w_gen_next >> SHIFT_A);
        w_z1       = w_mul_res ^ (w_mul_res >> SHIFT_B);
        w_draw     = w_mul_res ^ (w_mul_res >> SHIFT_C);
        w_in_acc   = s_axis_tvalid && s_axis_tready;
        w_keep     = r_z >= r_thr;
        w_load     = (r_fsm == ST_HOLD) && (!r_out_valid || m_axis_tready);
    end

    // Next state.
    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_fsm = (s_axis_tdata == '0) ? ST_DRAW : ST_THR_RUN;
                end
            end
            ST_THR_RUN: begin
                if (w_mod_stat.done) begin
                    n_fsm = ST_DRAW;
                end
            end
            ST_DRAW:  n_fsm = ST_MUL_A;
            ST_MUL_A: begin
                if (w_mul_stat.done) begin
                    n_fsm = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                if (w_mul_stat.done) begin
                    n_fsm = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!w_keep) begin
                    n_fsm = ST_DRAW;
                end else if (r_bound == '0) begin
                    n_fsm = ST_HOLD;
                end else begin
                    n_fsm = ST_RED_RUN;
                end
            end
            ST_RED_RUN: begin
                if (w_mod_stat.done) begin
                    n_fsm = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_load) begin
                    n_fsm = ST_IDLE;
                end
            end
            default: n_fsm = ST_IDLE;
        endcase
    end

    // Controller outputs: unit starts and operand selection.
    always_comb begin
        s_axis_tready = 1'b0;
        w_mul_start   = 1'b0;
        w_mul_a       = w_z0;
        w_mul_b       = MIX_MUL_A;
        w_mod_start   = 1'b0;
        w_mod_dvd     = r_z;
        w_mod_div     = r_bound;
        case (r_fsm)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_mod_dvd     = (~s_axis_tdata) + DW'(1);
                w_mod_div     = s_axis_tdata;
                w_mod_start   = w_in_acc && (s_axis_tdata != '0);
            end
            ST_DRAW: begin
                w_mul_start = 1'b1;
            end
            ST_MUL_A: begin
                w_mul_a     = w_z1;
                w_mul_b     = MIX_MUL_B;
                w_mul_start = w_mul_stat.done;
            end
            ST_CHECK: begin
                w_mod_start = w_keep && (r_bound != '0);
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    // Controller state and the generator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= ST_IDLE;
            r_gen <= '0;
        end else begin
            r_fsm <= n_fsm;
            if (i_cfg_we) begin
                r_gen <= i_cfg_wdata;
            end else if (r_fsm == ST_DRAW) begin
                r_gen <= w_gen_next;
            end
        end
    end

    // Per-item working registers.
    always_ff @(posedge i_clk) begin
        if (r_fsm == ST_IDLE && w_in_acc) begin
            r_bound <= s_axis_tdata;
            r_thr   <= '0;
        end
        if (r_fsm == ST_THR_RUN && w_mod_stat.done) begin
            r_thr <= w_mod_res;
        end
        if (r_fsm == ST_MUL_B && w_mul_stat.done) begin
            r_z <= w_draw;
        end
        if (r_fsm == ST_RED_RUN && w_mod_stat.done) begin
            r_z <= w_mod_res;
        end
    end

    // Output register, loaded from the controller when it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= r_z;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Shared serial units.
    sbi_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_stat    (w_mul_stat),
        .o_product (w_mul_res)
    );

    sbi_mod u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_mod_start),
        .i_dividend  (w_mod_dvd),
        .i_divisor   (w_mod_div),
        .o_stat      (w_mod_stat),
        .o_remainder (w_mod_res)
    );

    // A new request is only taken with both units idle.
    a_ready_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!w_mul_stat.busy && !w_mod_stat.busy))
        else $error("request taken while an arithmetic unit is busy");

    // The remainder unit is never started by a zero divisor.
    a_mod_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_start |-> (w_mod_div != '0))
        else $error("remainder unit started with a zero divisor");

    // Multiplier results only arrive while a mixing pass is expected.
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_stat.done |-> (r_fsm == ST_MUL_A || r_fsm == ST_MUL_B))
        else $error("multiplier finished outside a mixing pass");

    // A reduced index lies below its bound.
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_bound != '0) |=> (r_out_data < $past(r_bound)))
        else $error("index not below its bound");

    // A reduction only starts on a draw at or above the threshold.
    a_reduce_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_CHECK && w_mod_start) |-> (r_z >= r_thr))
        else $error("reduction started on a rejected draw");

endmodule
`default_nettype wire

/* hw/rtl/sbi_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbi_mul: bit-serial multiplier modulo 2^64
// Shift-and-add over one multiplier bit per cycle; the product keeps the low
// 64 bits. A start pulse loads the operands, done pulses when the product is
// ready, and a new start is taken in that same cycle.
// ----------------------------------------------------------------------------
module sbi_mul (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [sbi_pkg::DW-1:0]  i_a,
    input  wire logic [sbi_pkg::DW-1:0]  i_b,
    output sbi_pkg::t_unit_stat          o_stat,
    output logic [sbi_pkg::DW-1:0]       o_product
);
    import sbi_pkg::*;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_a;
    logic [DW-1:0] r_b;
    logic [DW-1:0] r_acc;

    // Control: busy for one step per multiplier bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= LAST_STEP;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: add the shifted multiplicand when the current bit is set.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + (r_b[0] ? r_a : '0);
            r_a   <= {r_a[DW-2:0], 1'b0};
            r_b   <= {1'b0, r_b[DW-1:1]};
        end
    end

    assign o_stat    = '{busy: r_busy, done: r_done};
    assign o_product = r_acc;

endmodule
`default_nettype wire

/* hw/rtl/sbi_mod.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbi_mod: bit-serial remainder unit
// Restoring division that brings in one dividend bit per cycle and keeps only
// the partial remainder. The divisor must be nonzero. Same start and done
// handshake as the multiplier.
// ----------------------------------------------------------------------------
module sbi_mod (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [sbi_pkg::DW-1:0]  i_dividend,
    input  wire logic [sbi_pkg::DW-1:0]  i_divisor,
    output sbi_pkg::t_unit_stat          o_stat,
    output logic [sbi_pkg::DW-1:0]       o_remainder
);
    import sbi_pkg::*;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [DW-1:0] r_div;
    logic [DW-1:0] r_rem;
    logic [DW:0]   w_shift;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // One restoring step: shift in the next bit, subtract if it fits.
    always_comb begin
        w_shift = {r_rem, r_dvd[DW-1]};
        w_ge    = w_shift >= {1'b0, r_div};
        w_diff  = w_shift - {1'b0, r_div};
    end

    // Control: busy for one step per dividend bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= LAST_STEP;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the partial remainder always stays below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_shift[DW-1:0];
        end
    end

    assign o_stat      = '{busy: r_busy, done: r_done};
    assign o_remainder = r_rem;

endmodule
`default_nettype wire
